[design/gstgc_pkg.sv]
// Package: widths, types, register indexes and helper functions of the turn gesture counter.
package gstgc_pkg;

  localparam int INDEX_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam int RATE_BITS  = 19;
  localparam int THR_BITS   = 20;
  localparam int GAP_BITS   = 16;
  localparam int TURN_BITS  = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = (THR_BITS > GAP_BITS) ? THR_BITS : GAP_BITS;

  localparam int SQ_W   = 2 * (RATE_BITS + 1);
  localparam int D2_W   = SQ_W + 2;
  localparam int T1_W   = THR_BITS + 1;
  localparam int TSQ_W  = 2 * T1_W;
  localparam int CMPD_W = (D2_W > TSQ_W) ? D2_W : TSQ_W;
  localparam int STEP_W = INDEX_BITS + 1;
  localparam int SUM_W  = ((COUNT_BITS > STEP_W) ? COUNT_BITS : STEP_W) + 1;
  localparam int EXIT_W = (COUNT_BITS > GAP_BITS) ? COUNT_BITS : GAP_BITS;

  localparam int THR_RESET = 1000;
  localparam int GAP_RESET = 10;

  typedef logic        [INDEX_BITS-1:0] index_t;
  typedef logic signed [RATE_BITS-1:0]  rate_t;
  typedef logic        [COUNT_BITS-1:0] count_t;
  typedef logic        [GAP_BITS-1:0]   gap_t;
  typedef logic        [TURN_BITS-1:0]  turn_t;
  typedef logic        [TSQ_W-1:0]      tsq_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic        [STEP_W-1:0]     step_t;
  typedef logic        [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  localparam tsq_t THR_SQ_RESET = tsq_t'((THR_RESET + 1) * (THR_RESET + 1));
  localparam gap_t EXIT_RESET   = gap_t'(GAP_RESET);
  localparam count_t COUNT_MAX  = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGULAR_THRESHOLD = 4'd0,
    REG_EXIT_GAP          = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    index_t sample_index;
    rate_t  angular_x;
    rate_t  angular_y;
    rate_t  angular_z;
  } in_item_t;

  typedef struct packed {
    logic  tracking_ended;
    turn_t turn_count;
    logic  sharp_step;
    logic  sample_lost;
  } result_t;

  typedef struct packed {
    index_t ref_index;
    rate_t  ref_x;
    rate_t  ref_y;
    rate_t  ref_z;
    logic   is_tracking;
    count_t stable_ticks;
    count_t turns_seen;
  } state_t;

  typedef struct packed {
    tsq_t thr_sq;
    gap_t exit_gap;
  } cfg_t;

  // Square of the difference of two rates, exact.
  function automatic sq_t sq_diff(rate_t a, rate_t b);
    logic signed [RATE_BITS:0] d;
    logic        [RATE_BITS:0] m;
    d = $signed({a[RATE_BITS-1], a}) - $signed({b[RATE_BITS-1], b});
    m = d[RATE_BITS] ? unsigned'(-d) : unsigned'(d);
    return sq_t'(m) * sq_t'(m);
  endfunction

  // Saturating counter add.
  function automatic count_t sat_add(count_t a, step_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(s);
  endfunction

endpackage

[design/gstgc_if.sv]
// Channel interfaces: sample request in, result request out.
interface gstgc_in_if import gstgc_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t sample_index;
  rate_t  angular_x;
  rate_t  angular_y;
  rate_t  angular_z;

  modport source (output valid, sample_index, angular_x, angular_y, angular_z, input ready);
  modport sink   (input valid, sample_index, angular_x, angular_y, angular_z, output ready);
endinterface

interface gstgc_out_if import gstgc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  tracking_ended;
  turn_t turn_count;
  logic  sharp_step;
  logic  sample_lost;

  modport source (output valid, tracking_ended, turn_count, sharp_step, sample_lost,
                  input ready);
  modport sink   (input valid, tracking_ended, turn_count, sharp_step, sample_lost,
                  output ready);
endinterface

[design/gyro_sharp_turn_gesture_counter_core.sv]
// Top level of the gyro sharp-turn gesture counter.
//
// Use:
//   in_chan  : one numbered gyro sample per request (index, X/Y/Z rates).
//   out_chan : exactly one result request per sample, in sample order.
//   cfg_*    : write port; index 0 = angular threshold, 1 = exit gap.
//              Write only while no sample is in flight.
// Path: a sample taken from in_chan is registered in stage 1 (s1_r),
//   processed by gstgc_step and registered in the result register, which drives out_chan.
// Throughput: one sample per cycle while out_chan is ready. The limit is the
//   combinational state loop: three 20x20 squares, their sum and the compare
//   against the stored (threshold+1)^2 decide the reference and counters
//   used by the following sample.
// Reset (rst_n low, synchronous): both channels empty, reference sample
//   and counters cleared, registers back to threshold 1000, exit gap 10.
// Stall: out_chan holds its request while ready is low. The input stage
//   still takes one more sample, then in_chan.ready drops until the
//   result register drains.
module gyro_sharp_turn_gesture_counter_core import gstgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  gstgc_in_if.sink          in_chan,
  gstgc_out_if.source       out_chan,
  input  logic              cfg_we,
  input  cfg_addr_t         cfg_index,
  input  cfg_data_t         cfg_data
);

  cfg_t     cfg;
  in_item_t s1_r, s1_nxt;
  logic     s1_v_r, s1_v_nxt;
  state_t   state_r, state_nxt, step_state;
  result_t  res_r, res_nxt, step_res;
  logic     out_v_r, out_v_nxt;
  logic     in_acc;
  logic     adv;

  gstgc_cfg u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_we),
    .addr (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  gstgc_step u_step (
    .item  (s1_r),
    .st    (state_r),
    .cfg   (cfg),
    .st_nxt(step_state),
    .res   (step_res)
  );

  // Stage 1 moves into the result register when that register is free or draining.
  assign adv           = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_nxt              = s1_r;
    s1_v_nxt            = s1_v_r;
    state_nxt           = state_r;
    res_nxt             = res_r;
    out_v_nxt           = out_v_r;

    if (out_chan.ready) out_v_nxt = 1'b0;
    if (adv) begin
      state_nxt = step_state;   // state commits only when the result is registered
      res_nxt   = step_res;
      out_v_nxt = 1'b1;
      s1_v_nxt  = 1'b0;
    end
    if (in_acc) begin
      s1_nxt.sample_index = in_chan.sample_index;
      s1_nxt.angular_x    = in_chan.angular_x;
      s1_nxt.angular_y    = in_chan.angular_y;
      s1_nxt.angular_z    = in_chan.angular_z;
      s1_v_nxt            = 1'b1;
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    res_r <= res_nxt;
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.tracking_ended = res_r.tracking_ended;
  assign out_chan.turn_count     = res_r.turn_count;
  assign out_chan.sharp_step     = res_r.sharp_step;
  assign out_chan.sample_lost    = res_r.sample_lost;

endmodule

[design/gstgc_cfg.sv]
// Configuration registers; the threshold is kept as (threshold + 1)^2.
module gstgc_cfg import gstgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      we,
  input  cfg_addr_t addr,
  input  cfg_data_t data,
  output cfg_t      cfg
);

  tsq_t             thr_sq_r, thr_sq_nxt;
  gap_t             exit_gap_r, exit_gap_nxt;
  logic [T1_W-1:0]  t1;

  always_comb begin
    t1           = T1_W'(data[THR_BITS-1:0]) + 1'b1;
    thr_sq_nxt   = thr_sq_r;
    exit_gap_nxt = exit_gap_r;
    if (we) begin
      unique case (addr)
        REG_ANGULAR_THRESHOLD: thr_sq_nxt   = tsq_t'(t1) * tsq_t'(t1);
        REG_EXIT_GAP:          exit_gap_nxt = data[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_sq_r   <= THR_SQ_RESET;
      exit_gap_r <= EXIT_RESET;
    end else begin
      thr_sq_r   <= thr_sq_nxt;
      exit_gap_r <= exit_gap_nxt;
    end
  end

  assign cfg.thr_sq   = thr_sq_r;
  assign cfg.exit_gap = exit_gap_r;

endmodule

[design/gstgc_step.sv]
// One sample step: continuity check, distance test, counters and end of movement.
module gstgc_step import gstgc_pkg::*; (
  input  in_item_t item,
  input  state_t   st,
  input  cfg_t     cfg,
  output state_t   st_nxt,
  output result_t  res
);

  index_t            gap_raw;
  step_t             gap;
  logic              cont;
  logic [D2_W-1:0]   d2;
  logic              sharp;
  state_t            mid;

  always_comb begin
    gap_raw = item.sample_index - st.ref_index;
    gap     = {gap_raw == '0, gap_raw};  // equal index means a full wrap
    cont    = (item.sample_index == index_t'(st.ref_index + 1'b1));
    d2      = D2_W'(sq_diff(item.angular_x, st.ref_x))
            + D2_W'(sq_diff(item.angular_y, st.ref_y))
            + D2_W'(sq_diff(item.angular_z, st.ref_z));
    sharp   = cont && (CMPD_W'(d2) >= CMPD_W'(cfg.thr_sq));

    mid = st;
    if (!cont) begin
      mid.ref_index = item.sample_index;
      mid.ref_x     = item.angular_x;
      mid.ref_y     = item.angular_y;
      mid.ref_z     = item.angular_z;
      if (st.is_tracking) mid.stable_ticks = sat_add(st.stable_ticks, gap);
    end else if (sharp) begin
      if (st.is_tracking) begin
        mid.turns_seen = sat_add(st.turns_seen, step_t'(1));
      end else begin
        mid.is_tracking = 1'b1;
        mid.turns_seen  = '0;
      end
      mid.stable_ticks = '0;
    end else begin
      if (st.is_tracking) mid.stable_ticks = sat_add(st.stable_ticks, step_t'(1));
      mid.ref_index = item.sample_index;
      mid.ref_x     = item.angular_x;
      mid.ref_y     = item.angular_y;
      mid.ref_z     = item.angular_z;
    end

    st_nxt             = mid;
    res.tracking_ended = 1'b0;
    res.turn_count     = '0;
    res.sharp_step     = sharp;
    res.sample_lost    = !cont;
    if (mid.is_tracking && (EXIT_W'(mid.stable_ticks) > EXIT_W'(cfg.exit_gap))) begin
      res.tracking_ended  = 1'b1;
      res.turn_count      = TURN_BITS'(mid.turns_seen);
      st_nxt.is_tracking  = 1'b0;
      st_nxt.stable_ticks = '0;
    end
  end

endmodule

[design/gstgc_checker.sv]
// Port-level checker for the gesture counter, bound to the top level.
module gstgc_checker import gstgc_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input logic  tracking_ended,
  input turn_t turn_count,
  input logic  sharp_step,
  input logic  sample_lost
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tracking_ended) &&
      $stable(turn_count) && $stable(sharp_step) && $stable(sample_lost))
    else $error("stalled result changed");

  a_count_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tracking_ended |-> turn_count == '0)
    else $error("turn count reported without end of movement");

  a_lost_not_sharp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_lost |-> !sharp_step)
    else $error("lost sample flagged sharp");

  a_sharp_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sharp_step |-> !tracking_ended)
    else $error("sharp step ended a movement");

endmodule

bind gyro_sharp_turn_gesture_counter_core gstgc_checker u_gstgc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .tracking_ended(out_chan.tracking_ended),
  .turn_count    (out_chan.turn_count),
  .sharp_step    (out_chan.sharp_step),
  .sample_lost   (out_chan.sample_lost)
);

[bench/tb.sv]
// Testbench for the gyro sharp-turn gesture counter: directed table, saturation run, random phases.
module tb;
  import gstgc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run control
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX    = 10;

  // Random part shape
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 125;
  localparam int PRESSURE_PHASE = 2;
  localparam int SAT_SHARPS    = 40;      // sharp steps in one long movement

  // Rate extremes of a 19-bit two's complement field, largest threshold and exit gap
  localparam int RATE_TOP    = 262143;
  localparam int RATE_BOTTOM = -262144;
  localparam int THR_TOP     = 1048575;
  localparam int GAP_TOP     = 65535;

  // A register index with no register behind it
  localparam cfg_addr_t REG_UNUSED = 4'd9;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_addr_t cfg_index;
  cfg_data_t cfg_data;

  gstgc_in_if  in_chan ();
  gstgc_out_if out_chan ();

  gyro_sharp_turn_gesture_counter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: reference sample, movement tracking and the register copy
  // ---------------------------------------------------------------------------
  index_t              anchor_index = '0;
  rate_t               anchor_x     = '0;
  rate_t               anchor_y     = '0;
  rate_t               anchor_z     = '0;
  logic                in_movement  = 1'b0;
  count_t              calm_ticks   = '0;
  count_t              turn_tally   = '0;
  logic [THR_BITS-1:0] thr_setting  = THR_BITS'(THR_RESET);
  gap_t                exit_setting = gap_t'(GAP_RESET);

  // Results still owed by the block, oldest first
  result_t pending_results[$];

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  hold_request = 1'b0;   // asks the result sink for one long stall
  bit  rx_steady    = 1'b0;   // result sink always ready

  typedef struct {
    in_item_t item;
    bit       typed;   // expectation written by hand
    result_t  want;
  } plan_row_t;

  plan_row_t directed_plan[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Saturating add on a counter
  function automatic count_t bump(count_t c, longint step);
    longint total;
    total = longint'(c) + step;
    return (total > longint'(COUNT_MAX)) ? COUNT_MAX : count_t'(total);
  endfunction

  // Expected result of one sample; advances the predictor state.
  function automatic result_t predict_turn_result(in_item_t s);
    result_t r;
    index_t  hop;
    longint  step;
    longint  dx;
    longint  dy;
    longint  dz;
    longint  dist_sq;
    longint  limit_sq;
    r = '0;
    if (s.sample_index != index_t'(anchor_index + 1'b1)) begin
      // index break: new reference, the gap counts as calm time
      hop  = index_t'(s.sample_index - anchor_index);
      step = (hop == '0) ? (longint'(1) << INDEX_BITS) : longint'(hop);
      r.sample_lost = 1'b1;
      anchor_index = s.sample_index;
      anchor_x     = s.angular_x;
      anchor_y     = s.angular_y;
      anchor_z     = s.angular_z;
      if (in_movement) calm_ticks = bump(calm_ticks, step);
    end else begin
      dx = longint'($signed(s.angular_x)) - longint'(anchor_x);
      dy = longint'($signed(s.angular_y)) - longint'(anchor_y);
      dz = longint'($signed(s.angular_z)) - longint'(anchor_z);
      dist_sq  = dx * dx + dy * dy + dz * dz;
      limit_sq = (longint'(thr_setting) + 1) * (longint'(thr_setting) + 1);
      if (dist_sq >= limit_sq) begin
        // sharp: reference stays put
        r.sharp_step = 1'b1;
        if (in_movement) begin
          turn_tally = bump(turn_tally, 1);
        end else begin
          in_movement = 1'b1;
          turn_tally  = '0;
        end
        calm_ticks = '0;
      end else begin
        if (in_movement) calm_ticks = bump(calm_ticks, 1);
        anchor_index = s.sample_index;
        anchor_x     = s.angular_x;
        anchor_y     = s.angular_y;
        anchor_z     = s.angular_z;
      end
    end
    if (in_movement && longint'(calm_ticks) > longint'(exit_setting)) begin
      r.tracking_ended = 1'b1;
      r.turn_count     = turn_tally;
      in_movement      = 1'b0;
      calm_ticks       = '0;
    end
    return r;
  endfunction

  function automatic rate_t clamp_rate(int v);
    if (v > RATE_TOP) return rate_t'(RATE_TOP);
    if (v < RATE_BOTTOM) return rate_t'(RATE_BOTTOM);
    return rate_t'(v);
  endfunction

  function automatic plan_row_t plan_row(int idx, int x, int y, int z, bit typed,
                                         bit ended, int turns, bit sharp, bit lost);
    plan_row_t row;
    row.item.sample_index  = index_t'(idx);
    row.item.angular_x     = rate_t'(x);
    row.item.angular_y     = rate_t'(y);
    row.item.angular_z     = rate_t'(z);
    row.typed              = typed;
    row.want.tracking_ended = ended;
    row.want.turn_count    = turn_t'(turns);
    row.want.sharp_step    = sharp;
    row.want.sample_lost   = lost;
    return row;
  endfunction

  // Random sample shaped around the current reference: mostly continuous
  // indexes, with quiet, sharp and boundary steps mixed in.
  function automatic in_item_t draw_sample(int sharp_pct);
    in_item_t s;
    int       r;
    int       m;
    int       q;
    int       thr;
    int       axis;
    int       sgn;
    int       base [3];
    int       v [3];
    base[0] = int'(anchor_x);
    base[1] = int'(anchor_y);
    base[2] = int'(anchor_z);
    thr  = int'(thr_setting);
    axis = $urandom_range(0, 2);
    sgn  = $urandom_range(0, 1) ? 1 : -1;
    r = $urandom_range(0, 99);
    if (r < 82)      s.sample_index = index_t'(anchor_index + 1'b1);
    else if (r < 90) s.sample_index = index_t'(anchor_index + $urandom_range(2, 40));
    else if (r < 94) s.sample_index = anchor_index;
    else             s.sample_index = index_t'($urandom);
    m = $urandom_range(0, 99);
    if (m < sharp_pct) begin
      for (int i = 0; i < 3; i++) v[i] = base[i] + $urandom_range(0, 4) - 2;
      v[axis] = base[axis] + sgn * (thr + 1 + $urandom_range(0, 3));
    end else if (m < sharp_pct + 10) begin
      // right on the threshold
      for (int i = 0; i < 3; i++) v[i] = base[i];
      v[axis] = base[axis] + sgn * (thr + $urandom_range(0, 1));
    end else if (m < sharp_pct + 18) begin
      for (int i = 0; i < 3; i++) v[i] = int'(rate_t'($urandom));
    end else begin
      q = thr / 2;
      for (int i = 0; i < 3; i++) v[i] = base[i] + int'($urandom_range(0, 2 * q)) - q;
    end
    s.angular_x = clamp_rate(v[0]);
    s.angular_y = clamp_rate(v[1]);
    s.angular_z = clamp_rate(v[2]);
    return s;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Offer one sample request; on acceptance record what the block owes.
  task automatic offer(input in_item_t s, input bit typed, input result_t want);
    result_t predicted;
    in_chan.valid        <= 1'b1;
    in_chan.sample_index <= s.sample_index;
    in_chan.angular_x    <= s.angular_x;
    in_chan.angular_y    <= s.angular_y;
    in_chan.angular_z    <= s.angular_z;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predicted = predict_turn_result(s);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result come out
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input cfg_addr_t a, input cfg_data_t d);
    cfg_we    <= 1'b1;
    cfg_index <= a;
    cfg_data  <= d;
    @(posedge clk);
    if (a == REG_ANGULAR_THRESHOLD) thr_setting = d[THR_BITS-1:0];
    else if (a == REG_EXIT_GAP)     exit_setting = d[GAP_BITS-1:0];
  endtask

  task automatic configure(input int unsigned thr, input int unsigned gap);
    cfg_data_t d;
    write_reg(REG_ANGULAR_THRESHOLD, cfg_data_t'(thr));
    // junk above the 16 gap bits must be dropped
    d = cfg_data_t'($urandom);
    d[GAP_BITS-1:0] = gap_t'(gap);
    write_reg(REG_EXIT_GAP, d);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, cfg_data_t'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random ready, one long stall on request, or always ready
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_steady) begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) begin
          out_chan.ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (n < 90) begin
          out_chan.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_chan.ready <= 1'b0;
          repeat ($urandom_range(5, 30)) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.tracking_ended = out_chan.tracking_ended;
      got.turn_count     = out_chan.turn_count;
      got.sharp_step     = out_chan.sharp_step;
      got.sample_lost    = out_chan.sample_lost;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result request with nothing owed: %s%0d %s%0d %s%0d %s%0d",
                   $realtime, "ended=", got.tracking_ended, "turns=", got.turn_count,
                   "sharp=", got.sharp_step, "lost=", got.sample_lost);
      end else begin
        want = pending_results.pop_front();
        if (got.tracking_ended !== want.tracking_ended ||
            got.turn_count     !== want.turn_count ||
            got.sharp_step     !== want.sharp_step ||
            got.sample_lost    !== want.sample_lost) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"%0t: mismatch exp ended=%0d turns=%0d sharp=%0d lost=%0d",
                      " got ended=%0d turns=%0d sharp=%0d lost=%0d"},
                     $realtime, want.tracking_ended, want.turn_count, want.sharp_step,
                     want.sample_lost, got.tracking_ended, got.turn_count,
                     got.sharp_step, got.sample_lost);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t    s;
    result_t     none;
    int          thr_pick;
    int          gap_pick;
    int          sharp_pct;
    bit          pressure;

    none = '0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.sample_index <= '0;
    in_chan.angular_x    <= '0;
    in_chan.angular_y    <= '0;
    in_chan.angular_z    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown index with all ones: the directed rows below rely on the
    // reset threshold 1000 and exit gap 10 still being in place.
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    @(posedge clk);

    // Directed table, reset registers (threshold 1000 -> limit 1001^2)
    directed_plan.push_back(plan_row(1, 0, 0, 0, 1, 0, 0, 0, 0));          // quiet
    directed_plan.push_back(plan_row(2, 1001, 0, 0, 1, 0, 0, 1, 0));       // exactly at limit
    directed_plan.push_back(plan_row(2, 1000, 0, 0, 1, 0, 0, 0, 0));       // just under, new ref
    directed_plan.push_back(plan_row(3, 1000, 0, -1001, 0, 0, 0, 0, 0));   // turn while tracking
    directed_plan.push_back(plan_row(3, 1000, 0, 0, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(9, -5, 7, 3, 1, 0, 0, 0, 1));         // index gap of 6
    directed_plan.push_back(plan_row(10, -5, 7, 3, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(11, -5, 7, 3, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(12, -5, 7, 3, 0, 0, 0, 0, 0));        // calm == exit gap
    directed_plan.push_back(plan_row(13, -5, 7, 3, 1, 1, 1, 0, 0));        // calm > gap, one turn
    directed_plan.push_back(plan_row(65535, RATE_TOP, RATE_BOTTOM, RATE_TOP, 1, 0, 0, 0, 1));
    directed_plan.push_back(plan_row(0, RATE_TOP, RATE_BOTTOM, RATE_TOP, 1, 0, 0, 0, 0)); // wrap
    directed_plan.push_back(plan_row(1, RATE_BOTTOM, RATE_TOP, RATE_BOTTOM, 1, 0, 0, 1, 0));
    directed_plan.push_back(plan_row(0, 0, 0, 0, 1, 1, 0, 0, 1));          // same index: end, no turns
    directed_plan.push_back(plan_row(1, 0, 0, 0, 1, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(2, 200000, 200000, 200000, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(2, 1, 1, 1, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(3, -200000, -200000, -200000, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(100, 5, 5, 5, 0, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(101, -1, -1, -1, 0, 0, 0, 0, 0));
    foreach (directed_plan[i]) begin
      offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      pause_sender(sender_gap());
    end
    drain();

    // Long movement: threshold 0 makes every changed sample sharp; the
    // reference never moves, so the turns pile up.
    rx_steady = 1'b1;
    configure(0, GAP_TOP);
    for (int k = 0; k < SAT_SHARPS; k++) begin
      s.sample_index = index_t'(anchor_index + 1'b1);
      s.angular_x    = (int'(anchor_x) == RATE_TOP) ? rate_t'(anchor_x - 1'b1)
                                                     : rate_t'(anchor_x + 1'b1);
      s.angular_y    = anchor_y;
      s.angular_z    = anchor_z;
      offer(s, 1'b0, none);
    end
    // full-period gaps pin the calm counter, still not above 65535
    for (int k = 0; k < 3; k++) begin
      s.sample_index = anchor_index;
      offer(s, 1'b0, none);
    end
    drain();
    // exit gap 0: the next gap ends the movement and reports its turns
    configure(0, 0);
    s.sample_index = anchor_index;
    offer(s, 1'b0, none);
    drain();
    rx_steady = 1'b0;

    // Random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin thr_pick = 0;       gap_pick = 0;       end
        1: begin thr_pick = THR_TOP; gap_pick = GAP_TOP; end
        PRESSURE_PHASE: begin thr_pick = THR_RESET; gap_pick = GAP_RESET; end
        default: begin
          case ($urandom_range(0, 4))
            0: thr_pick = 0;
            1: thr_pick = $urandom_range(1, 50);
            2: thr_pick = $urandom_range(100, 5000);
            3: thr_pick = $urandom_range(0, THR_TOP);
            default: thr_pick = THR_TOP;
          endcase
          case ($urandom_range(0, 3))
            0: gap_pick = 0;
            1: gap_pick = $urandom_range(1, 20);
            2: gap_pick = $urandom_range(0, GAP_TOP);
            default: gap_pick = GAP_TOP;
          endcase
        end
      endcase
      case ($urandom_range(0, 2))
        0: sharp_pct = 5;
        1: sharp_pct = 15;
        default: sharp_pct = 40;
      endcase
      configure(thr_pick, gap_pick);
      // in the pressure phase the sink stalls long while samples keep coming
      pressure = (phase == PRESSURE_PHASE);
      if (pressure) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer(draw_sample(sharp_pct), 1'b0, none);
        if (!pressure) pause_sender(sender_gap());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/gstgc_pkg.sv
design/gstgc_if.sv
design/gstgc_cfg.sv
design/gstgc_step.sv
design/gyro_sharp_turn_gesture_counter_core.sv
design/gstgc_checker.sv
bench/tb.sv
